// File: sv/btt_pkg.sv
// shared types and codes for the buffer tracking table
package btt_pkg;

   // operation codes carried on req_mode
   localparam logic [2:0] MODE_REG       = 3'd0;
   localparam logic [2:0] MODE_UNREG     = 3'd1;
   localparam logic [2:0] MODE_ACC       = 3'd2;
   localparam logic [2:0] MODE_ACC_EPOCH = 3'd3;
   localparam logic [2:0] MODE_CLASSIFY  = 3'd4;
   localparam logic [2:0] MODE_READ      = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   // buffer classes
   localparam logic [1:0] CLS_UNKNOWN    = 2'd0;
   localparam logic [1:0] CLS_PERSISTENT = 2'd1;
   localparam logic [1:0] CLS_EPHEMERAL  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_LIFE = 2'd0;
   localparam logic [1:0] CSR_THR  = 2'd1;
   localparam logic [1:0] CSR_MINB = 2'd2;

   // configuration reset values
   localparam logic [47:0] LIFE_RST = 48'd10;
   localparam logic [31:0] THR_RST  = 32'd10;
   localparam logic [39:0] MINB_RST = 40'd1048576;

   // one stored buffer record
   typedef struct packed {
      logic        active;
      logic [47:0] address;
      logic [39:0] bytes;
      logic [47:0] birth;
      logic [47:0] recent;
      logic [31:0] hits;
      logic [1:0]  cls;
   } record_type;

   // classification thresholds
   typedef struct packed {
      logic [47:0] life;
      logic [31:0] thr;
      logic [39:0] minb;
   } cfg_type;

   // what the shared unit reports for one record
   typedef struct packed {
      logic       hit;
      logic       free;
      record_type upd;
      record_type cls;
   } eval_type;

endpackage

// File: sv/buffer_tracking_table.sv
// buffer tracking table: top level with sequencer, record memory and shared unit
//
// Usage: drive req_* and pulse start while busy is low; the operation is
// taken at that edge. Exactly one result follows, shown on rsp_* for one
// cycle with strobe high; the receiver cannot hold it off, so it must take
// it in that cycle. Thresholds are written through csr_valid/csr_ready
// (always ready) with csr_index 0..2; write them only while idle.
// Records sit in one memory; a single record is read per cycle and fed to
// the shared compare/update unit, so lookups and the classify sweep walk
// the table one slot a cycle.
// Register, unregister and access walk the table until a hit, which ends the
// walk early; classify always walks every slot; read entry reads the one
// slot named; an undefined mode or an index out of range answers on the next
// cycle. A new operation may start in the cycle the strobe is shown.
// After reset a clearing pass zeroes every slot of the memory, one slot a
// cycle; busy stays high meanwhile, configuration writes are still taken.
module buffer_tracking_table
   import btt_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // operation transfer
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [47:0] req_buffer_address,
   input  logic [39:0] req_buffer_bytes,
   input  logic [47:0] req_epoch_now,
   input  logic [5:0]  req_entry_index,
   // result transfer
   output logic        strobe,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_slot,
   output logic [6:0]  rsp_active_total,
   output logic        rsp_entry_active,
   output logic [47:0] rsp_entry_address,
   output logic [39:0] rsp_entry_bytes,
   output logic [47:0] rsp_entry_birth_epoch,
   output logic [47:0] rsp_entry_recent_epoch,
   output logic [31:0] rsp_entry_hits,
   output logic [1:0]  rsp_entry_class,
   // configuration transfer
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_RD_ADDR,
      S_RD_DATA
   } state_type;

   state_type   state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [IW-1:0] issue_ff, issue_in;
   logic        issue_on_ff, issue_on_in;
   logic        pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0] pipe_idx_ff, pipe_idx_in;
   logic        free_ok_ff, free_ok_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] act_cnt_ff, act_cnt_in;

   // latched request
   logic [2:0]  mode_ff, mode_in;
   logic [47:0] addr_ff, addr_in;
   logic [39:0] bytes_ff, bytes_in;
   logic [47:0] now_ff, now_in;
   logic [5:0]  index_ff, index_in;

   // thresholds
   cfg_type     cfg_ff, cfg_in;

   // registered result
   logic        rsp_vld_ff, rsp_vld_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [5:0]  rsp_slot_ff, rsp_slot_in;
   logic [6:0]  rsp_total_ff, rsp_total_in;
   record_type  rsp_rec_ff, rsp_rec_in;

   // memory ports
   logic        wr_en;
   logic [IW-1:0] wr_addr;
   record_type  wr_data;
   logic [IW-1:0] rd_addr;
   record_type  rd_data;
   eval_type    ev;
   record_type  new_rec;

   btt_ram #(
      .WIDTH ($bits(record_type)),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   btt_unit u_unit (
      .rec  (rd_data),
      .mode (mode_ff),
      .key  (addr_ff),
      .now  (now_ff),
      .cfg  (cfg_ff),
      .ev   (ev)
   );

   // record for a fresh registration
   always_comb begin
      new_rec         = '0;
      new_rec.active  = 1'b1;
      new_rec.address = addr_ff;
      new_rec.bytes   = bytes_ff;
      new_rec.birth   = now_ff;
      new_rec.recent  = now_ff;
      new_rec.hits    = '0;
      new_rec.cls     = CLS_UNKNOWN;
   end

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LIFE: cfg_in.life = csr_wdata;
            CSR_THR:  cfg_in.thr  = csr_wdata[31:0];
            CSR_MINB: cfg_in.minb = csr_wdata[39:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   // read address per state
   always_comb begin
      case (state_ff)
         S_RD_ADDR: rd_addr = IW'(index_ff);
         default:   rd_addr = issue_ff;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      issue_in      = issue_ff;
      issue_on_in   = issue_on_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      act_cnt_in    = act_cnt_ff;
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      bytes_in      = bytes_ff;
      now_in        = now_ff;
      index_in      = index_ff;
      rsp_vld_in    = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_rec_in    = rsp_rec_ff;
      wr_en         = 1'b0;
      wr_addr       = pipe_idx_ff;
      wr_data       = ev.upd;

      case (state_ff)
         // zero every slot after reset
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + IW'(1);
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end

         // take a new operation
         S_IDLE: begin
            if (start) begin
               mode_in     = req_mode;
               addr_in     = req_buffer_address;
               bytes_in    = req_buffer_bytes;
               now_in      = req_epoch_now;
               index_in    = req_entry_index;
               issue_in    = '0;
               issue_on_in = 1'b1;
               free_ok_in  = 1'b0;
               rsp_status_in = ST_OK;
               rsp_slot_in   = '0;
               rsp_rec_in    = '0;
               case (req_mode)
                  MODE_REG, MODE_UNREG, MODE_ACC, MODE_ACC_EPOCH, MODE_CLASSIFY: begin
                     state_in = S_SCAN;
                  end
                  MODE_READ: begin
                     if (32'(req_entry_index) >= SLOTS) begin
                        rsp_vld_in    = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        state_in = S_RD_ADDR;
                     end
                  end
                  default: begin
                     rsp_vld_in = 1'b1;
                  end
               endcase
            end
         end

         // walk the table one slot a cycle
         S_SCAN: begin
            pipe_vld_in = issue_on_ff;
            pipe_idx_in = issue_ff;
            if (issue_on_ff) begin
               issue_in = issue_ff + IW'(1);
               if (issue_ff == LAST) begin
                  issue_on_in = 1'b0;
               end
            end
            if (pipe_vld_ff) begin
               if (mode_ff == MODE_CLASSIFY) begin
                  wr_en   = rd_data.active;
                  wr_data = ev.cls;
                  if (pipe_idx_ff == LAST) begin
                     rsp_vld_in = 1'b1;
                     state_in   = S_IDLE;
                  end
               end else if (ev.hit) begin
                  wr_en       = 1'b1;
                  wr_data     = ev.upd;
                  rsp_vld_in  = 1'b1;
                  rsp_slot_in = 6'(pipe_idx_ff);
                  state_in    = S_IDLE;
                  if (mode_ff == MODE_UNREG) begin
                     act_cnt_in = act_cnt_ff - CW'(1);
                  end
               end else begin
                  if (ev.free && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = pipe_idx_ff;
                  end
                  if (pipe_idx_ff == LAST) begin
                     rsp_vld_in = 1'b1;
                     state_in   = S_IDLE;
                     if (mode_ff != MODE_REG) begin
                        rsp_status_in = ST_MISS;
                     end else if (free_ok_ff || ev.free) begin
                        wr_en       = 1'b1;
                        wr_addr     = free_ok_ff ? free_idx_ff : pipe_idx_ff;
                        wr_data     = new_rec;
                        act_cnt_in  = act_cnt_ff + CW'(1);
                        rsp_slot_in = 6'(wr_addr);
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
               end
            end
         end

         // read entry: address goes out
         S_RD_ADDR: begin
            state_in = S_RD_DATA;
         end

         // read entry: record comes back
         S_RD_DATA: begin
            rsp_vld_in  = 1'b1;
            rsp_slot_in = index_ff;
            rsp_rec_in  = rd_data;
            state_in    = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_total_in = 7'(act_cnt_in);
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         issue_on_ff <= 1'b0;
         pipe_vld_ff <= 1'b0;
         free_ok_ff  <= 1'b0;
         act_cnt_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
         cfg_ff.life <= LIFE_RST;
         cfg_ff.thr  <= THR_RST;
         cfg_ff.minb <= MINB_RST;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         issue_on_ff <= issue_on_in;
         pipe_vld_ff <= pipe_vld_in;
         free_ok_ff  <= free_ok_in;
         act_cnt_ff  <= act_cnt_in;
         rsp_vld_ff  <= rsp_vld_in;
         cfg_ff      <= cfg_in;
      end
      issue_ff      <= issue_in;
      pipe_idx_ff   <= pipe_idx_in;
      free_idx_ff   <= free_idx_in;
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      bytes_ff      <= bytes_in;
      now_ff        <= now_in;
      index_ff      <= index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_rec_ff    <= rsp_rec_in;
   end

   // port drive
   assign busy                   = (state_ff != S_IDLE);
   assign strobe                 = rsp_vld_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_slot               = rsp_slot_ff;
   assign rsp_active_total       = rsp_total_ff;
   assign rsp_entry_active       = rsp_rec_ff.active;
   assign rsp_entry_address      = rsp_rec_ff.address;
   assign rsp_entry_bytes        = rsp_rec_ff.bytes;
   assign rsp_entry_birth_epoch  = rsp_rec_ff.birth;
   assign rsp_entry_recent_epoch = rsp_rec_ff.recent;
   assign rsp_entry_hits         = rsp_rec_ff.hits;
   assign rsp_entry_class        = rsp_rec_ff.cls;

   // a result always leaves the sequencer idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe |-> !busy)
      else $error("result shown while sequencer busy");

   // an accepted operation either runs or answers at once
   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || strobe))
      else $error("accepted operation dropped");

   // the running count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      act_cnt_ff <= CW'(SLOTS))
      else $error("active count above table size");

   // table full only when every slot is active
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (strobe && (rsp_status == ST_FULL)) |-> (rsp_active_total == 7'(SLOTS)))
      else $error("full reported with free slots");

endmodule

// File: sv/btt_ram.sv
// generic simple dual-port ram with registered read
module btt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/btt_unit.sv
// shared compare and update unit applied to one record per cycle
module btt_unit
   import btt_pkg::*;
(
   input  record_type  rec,
   input  logic [2:0]  mode,
   input  logic [47:0] key,
   input  logic [47:0] now,
   input  cfg_type     cfg,
   output eval_type    ev
);

   logic [47:0] life;
   logic [31:0] hits_bump;
   logic        is_pers;

   // saturating access count
   assign hits_bump = (rec.hits != '1) ? rec.hits + 32'd1 : rec.hits;

   // lifetime with wrap
   assign life    = now - rec.birth;
   assign is_pers = (life >= cfg.life) && (rec.hits >= cfg.thr) && (rec.bytes >= cfg.minb);

   always_comb begin
      // key match and free slot detection
      ev.hit  = rec.active && (rec.address == key);
      ev.free = !rec.active;

      // record after a hit, per operation
      ev.upd = rec;
      case (mode)
         MODE_REG, MODE_ACC_EPOCH: begin
            ev.upd.recent = now;
            ev.upd.hits   = hits_bump;
         end
         MODE_ACC: begin
            ev.upd.hits = hits_bump;
         end
         MODE_UNREG: begin
            ev.upd.active = 1'b0;
         end
         default: begin
            ev.upd = rec;
         end
      endcase

      // class from thresholds
      ev.cls = rec;
      if (is_pers) begin
         ev.cls.cls = CLS_PERSISTENT;
      end else if (life < cfg.life) begin
         ev.cls.cls = CLS_UNKNOWN;
      end else begin
         ev.cls.cls = CLS_EPHEMERAL;
      end
   end

endmodule

// File: dv/tb_buffer_tracking_table.sv
// testbench for the buffer tracking table: directed and random operations checked on a shadow table
module tb_buffer_tracking_table;
   timeunit 1ns;
   timeprecision 1ps;

   import btt_pkg::*;

   localparam int SLOTS       = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int POOL_MAX    = 72;

   // modes the block treats as no-ops
   localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
   localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

   // one operation as driven on the req_ ports
   typedef struct {
      logic [2:0]  mode;
      logic [47:0] address;
      logic [39:0] bytes;
      logic [47:0] epoch;
      logic [5:0]  index;
   } table_op_type;

   // one result as expected on the rsp_ ports
   typedef struct {
      logic [1:0] status;
      logic [5:0] slot;
      logic [6:0] total;
      record_type entry;
   } table_rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_mode;
   logic [47:0] req_buffer_address;
   logic [39:0] req_buffer_bytes;
   logic [47:0] req_epoch_now;
   logic [5:0]  req_entry_index;
   logic        strobe;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_slot;
   logic [6:0]  rsp_active_total;
   logic        rsp_entry_active;
   logic [47:0] rsp_entry_address;
   logic [39:0] rsp_entry_bytes;
   logic [47:0] rsp_entry_birth_epoch;
   logic [47:0] rsp_entry_recent_epoch;
   logic [31:0] rsp_entry_hits;
   logic [1:0]  rsp_entry_class;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [47:0] csr_wdata;

   // shadow copy of the table and thresholds
   record_type     shadow_rec [SLOTS];
   int             shadow_count;
   cfg_type        shadow_cfg;
   table_rsp_type  expected_rsp_q [$];

   logic [47:0] addr_pool [POOL_MAX];
   int          pool_size;
   logic [47:0] epoch_clock;
   int          error_count;
   int          cycle_count;

   buffer_tracking_table #(.SLOTS(SLOTS)) dut (.*);

   // clock generation
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // random values at field widths
   function automatic logic [47:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[47:0];
   endfunction

   function automatic logic [39:0] rand40();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[39:0];
   endfunction

   function automatic table_op_type make_op(logic [2:0] mode, logic [47:0] address,
                                            logic [39:0] bytes, logic [47:0] epoch,
                                            logic [5:0] index);
      table_op_type op;
      op.mode    = mode;
      op.address = address;
      op.bytes   = bytes;
      op.epoch   = epoch;
      op.index   = index;
      return op;
   endfunction

   // active slot holding an address, or -1
   function automatic int find_slot(logic [47:0] address);
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_rec[i].active && shadow_rec[i].address == address) return i;
      end
      return -1;
   endfunction

   function automatic int first_free_slot();
      for (int i = 0; i < SLOTS; i++) begin
         if (!shadow_rec[i].active) return i;
      end
      return -1;
   endfunction

   // saturating access count
   function automatic void bump_hits(int i);
      if (shadow_rec[i].hits != 32'hFFFF_FFFF) shadow_rec[i].hits = shadow_rec[i].hits + 1;
   endfunction

   // apply one operation to the shadow table and return its result
   function automatic table_rsp_type predict_table_op(table_op_type op);
      table_rsp_type rsp;
      int            hit;
      logic [47:0]   life;
      rsp.status = ST_OK;
      rsp.slot   = '0;
      rsp.entry  = '0;
      case (op.mode)
         MODE_REG: begin
            hit = find_slot(op.address);
            if (hit >= 0) begin
               shadow_rec[hit].recent = op.epoch;
               bump_hits(hit);
               rsp.slot = hit[5:0];
            end else begin
               hit = first_free_slot();
               if (hit < 0) begin
                  rsp.status = ST_FULL;
               end else begin
                  shadow_rec[hit] = '{active: 1'b1, address: op.address, bytes: op.bytes,
                                      birth: op.epoch, recent: op.epoch, hits: '0,
                                      cls: CLS_UNKNOWN};
                  shadow_count++;
                  rsp.slot = hit[5:0];
               end
            end
         end
         MODE_UNREG, MODE_ACC, MODE_ACC_EPOCH: begin
            hit = find_slot(op.address);
            if (hit < 0) begin
               rsp.status = ST_MISS;
            end else begin
               rsp.slot = hit[5:0];
               if (op.mode == MODE_UNREG) begin
                  shadow_rec[hit].active = 1'b0;
                  shadow_count--;
               end else begin
                  if (op.mode == MODE_ACC_EPOCH) shadow_rec[hit].recent = op.epoch;
                  bump_hits(hit);
               end
            end
         end
         MODE_CLASSIFY: begin
            // lifetime wraps at 48 bits
            for (int i = 0; i < SLOTS; i++) begin
               if (shadow_rec[i].active) begin
                  life = op.epoch - shadow_rec[i].birth;
                  if (life >= shadow_cfg.life && shadow_rec[i].hits >= shadow_cfg.thr &&
                      shadow_rec[i].bytes >= shadow_cfg.minb)
                     shadow_rec[i].cls = CLS_PERSISTENT;
                  else if (life < shadow_cfg.life)
                     shadow_rec[i].cls = CLS_UNKNOWN;
                  else
                     shadow_rec[i].cls = CLS_EPHEMERAL;
               end
            end
         end
         MODE_READ: begin
            rsp.slot  = op.index;
            rsp.entry = shadow_rec[op.index];
         end
         default: ;
      endcase
      rsp.total = shadow_count[6:0];
      return rsp;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : rsp_check
      table_rsp_type want;
      if (!reset && strobe !== 1'b0) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("status", rsp_status, want.status);
            check_field("slot", rsp_slot, want.slot);
            check_field("active_total", rsp_active_total, want.total);
            check_field("entry_active", rsp_entry_active, want.entry.active);
            check_field("entry_address", rsp_entry_address, want.entry.address);
            check_field("entry_bytes", rsp_entry_bytes, want.entry.bytes);
            check_field("entry_birth_epoch", rsp_entry_birth_epoch, want.entry.birth);
            check_field("entry_recent_epoch", rsp_entry_recent_epoch, want.entry.recent);
            check_field("entry_hits", rsp_entry_hits, want.entry.hits);
            check_field("entry_class", rsp_entry_class, want.entry.cls);
         end
      end
   end

   // cycle counter with a generous limit
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // one operation transfer after an optional gap
   task automatic send_op(table_op_type op, int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start              <= 1'b1;
      req_mode           <= op.mode;
      req_buffer_address <= op.address;
      req_buffer_bytes   <= op.bytes;
      req_epoch_now      <= op.epoch;
      req_entry_index    <= op.index;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      expected_rsp_q.push_back(predict_table_op(op));
   endtask

   // drop start, then wait until every expected result has come
   task automatic wait_for_results(int settle);
      @(negedge clock);
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // one register write transfer
   task automatic write_csr(logic [1:0] idx, logic [47:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         CSR_LIFE: shadow_cfg.life = data;
         CSR_THR:  shadow_cfg.thr  = data[31:0];
         CSR_MINB: shadow_cfg.minb = data[39:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // thresholds are only written while the table is idle; unused upper bits get noise
   task automatic set_thresholds(logic [47:0] life, logic [31:0] thr, logic [39:0] minb);
      wait_for_results(4);
      write_csr(CSR_LIFE, life);
      write_csr(CSR_THR, {16'($urandom), thr});
      write_csr(CSR_MINB, {8'($urandom), minb});
   endtask

   function automatic int sender_gap(int idle_pct);
      int g;
      g = 0;
      while (g < 40 && $urandom_range(0, 99) < idle_pct) g++;
      return g;
   endfunction

   // random operation, mostly on a pool of known addresses
   function automatic table_op_type random_op();
      table_op_type op;
      int           r;
      int           s;
      r = $urandom_range(0, 99);
      epoch_clock = epoch_clock + 48'($urandom_range(0, 3));
      if (r < 30)      op.mode = MODE_REG;
      else if (r < 42) op.mode = MODE_UNREG;
      else if (r < 57) op.mode = MODE_ACC;
      else if (r < 72) op.mode = MODE_ACC_EPOCH;
      else if (r < 82) op.mode = MODE_CLASSIFY;
      else if (r < 97) op.mode = MODE_READ;
      else             op.mode = r[0] ? MODE_UNDEF_HI : MODE_UNDEF_LO;
      op.address = ($urandom_range(0, 99) < 88) ? addr_pool[$urandom_range(0, pool_size - 1)]
                                                : rand48();
      op.epoch = ($urandom_range(0, 99) < 94) ? epoch_clock : rand48();
      case ($urandom_range(0, 2))
         0:       op.bytes = rand40();
         1:       op.bytes = shadow_cfg.minb + 40'($urandom_range(0, 8)) - 40'd4;
         default: op.bytes = 40'($urandom_range(0, 4096));
      endcase
      s = find_slot(op.address);
      op.index = (s >= 0 && $urandom_range(0, 1)) ? s[5:0] : 6'($urandom_range(0, SLOTS - 1));
      return op;
   endfunction

   // reads and a sweep on the empty table right after the clearing pass
   task automatic test_reset_state();
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd0), 0);
      send_op(make_op(MODE_READ, '1, '1, '1, 6'd63), 0);
      send_op(make_op(MODE_CLASSIFY, '0, '0, '0, '0), 1);
   endtask

   // field extremes, every mode and the named corner cases
   task automatic test_directed_ops();
      logic [47:0] other;
      other = 48'hAAAA_AAAA_AAAA;
      send_op(make_op(MODE_REG, '0, '1, '1, '0), 0);
      send_op(make_op(MODE_REG, '1, '0, '0, '1), 1);
      // known address: recent epoch and count only, size kept
      send_op(make_op(MODE_REG, '0, 40'd5, 48'd7, '0), 0);
      send_op(make_op(MODE_ACC, '1, '0, '0, '0), 2);
      send_op(make_op(MODE_ACC_EPOCH, '1, '0, 48'h5555_5555_5555, '0), 0);
      // misses
      send_op(make_op(MODE_ACC, 48'h123, '0, '0, '0), 0);
      send_op(make_op(MODE_UNREG, 48'h123, '0, '0, '0), 1);
      send_op(make_op(MODE_ACC_EPOCH, 48'h124, '0, 48'd9, '0), 0);
      // lifetime wraps for the record born at the top epoch
      send_op(make_op(MODE_CLASSIFY, '0, '0, 48'd20, '0), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd0), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd1), 2);
      // unregister leaves stale fields, next register reuses the lowest free slot
      send_op(make_op(MODE_UNREG, '1, '0, '0, '0), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd1), 0);
      send_op(make_op(MODE_REG, other, 40'h55_5555_5555, 48'd3, '0), 1);
      send_op(make_op(MODE_CLASSIFY, '0, '0, 48'd5, '0), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd1), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd0), 0);
      send_op(make_op(MODE_UNDEF_LO, rand48(), rand40(), rand48(), 6'd2), 0);
      send_op(make_op(MODE_UNDEF_HI, '0, '0, '0, '0), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd63), 1);
   endtask

   // thresholds at zero, at full scale, and a persistent record at the reset values
   task automatic test_threshold_extremes();
      set_thresholds('0, '0, '0);
      send_op(make_op(MODE_CLASSIFY, '0, '0, rand48(), '0), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd0), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd1), 0);
      set_thresholds('1, '1, '1);
      send_op(make_op(MODE_CLASSIFY, '0, '0, 48'hFFFF_FFFF_FFFE, '0), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd0), 0);
      send_op(make_op(MODE_CLASSIFY, '0, '0, '0, '0), 1);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd0), 0);
      set_thresholds(LIFE_RST, THR_RST, MINB_RST);
      for (int n = 0; n < 10; n++) begin
         send_op(make_op(n[0] ? MODE_ACC : MODE_ACC_EPOCH, '0, '0, 48'(50 + n), '0),
                 $urandom_range(0, 1));
      end
      send_op(make_op(MODE_CLASSIFY, '0, '0, 48'd100, '0), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, 6'd0), 0);
   endtask

   // fill every slot, hit the full case, reuse a freed slot, then empty the table
   task automatic test_table_full();
      int victim;
      while (shadow_count < SLOTS) begin
         send_op(make_op(MODE_REG, rand48(), rand40(), rand48(), '0), $urandom_range(0, 2));
      end
      send_op(make_op(MODE_REG, rand48(), rand40(), rand48(), '0), 0);
      victim = $urandom_range(1, SLOTS - 2);
      send_op(make_op(MODE_UNREG, shadow_rec[victim].address, '0, '0, '0), 0);
      send_op(make_op(MODE_REG, rand48(), rand40(), rand48(), '0), 0);
      send_op(make_op(MODE_READ, '0, '0, '0, victim[5:0]), 0);
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_rec[i].active)
            send_op(make_op(MODE_UNREG, shadow_rec[i].address, rand40(), rand48(), 6'(i)),
                    $urandom_range(0, 1));
      end
   endtask

   // random traffic at one sender idle rate on a pool of addresses
   task automatic test_random_traffic(int idle_pct, int count, int pool_n,
                                      logic [47:0] epoch_base);
      pool_size   = pool_n;
      epoch_clock = epoch_base;
      set_thresholds(48'($urandom_range(0, 40)), 32'($urandom_range(0, 15)),
                     40'($urandom_range(0, 2_000_000)));
      for (int n = 0; n < count; n++) begin
         send_op(random_op(), sender_gap(idle_pct));
         // pause now and then until the table has answered everything
         if ($urandom_range(0, 99) == 0) wait_for_results(0);
      end
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_mode           = '0;
      req_buffer_address = '0;
      req_buffer_bytes   = '0;
      req_epoch_now      = '0;
      req_entry_index    = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      error_count        = 0;
      shadow_count       = 0;
      shadow_cfg         = '{life: LIFE_RST, thr: THR_RST, minb: MINB_RST};
      for (int i = 0; i < SLOTS; i++) shadow_rec[i] = '0;
      // address pool, extremes included
      for (int i = 0; i < POOL_MAX; i++) addr_pool[i] = rand48();
      addr_pool[3] = '0;
      addr_pool[5] = '1;
      pool_size    = POOL_MAX;
      epoch_clock  = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_directed_ops();
      test_threshold_extremes();
      test_table_full();
      test_random_traffic(30, 525, 16, 48'd1000);
      test_random_traffic(48, 525, POOL_MAX, 48'hFFFF_FFFF_FF00);
      test_random_traffic(0, 525, 40, rand48());

      wait_for_results(SLOTS + 4);
      if (expected_rsp_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rsp_q.size()));
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/btt_pkg.sv
sv/btt_ram.sv
sv/btt_unit.sv
sv/buffer_tracking_table.sv
dv/tb_buffer_tracking_table.sv
